### src/ppfr_pkg.sv
// Shared types and constants of the preamble/postamble frame receiver.
package ppfr_pkg;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'hFE;
    localparam logic [7:0] POSTAMBLE_BYTE = 8'hFD;
    localparam int unsigned COUNT_W       = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        EV_PASS      = 4'd0,
        EV_HUNT      = 4'd1,
        EV_HUNT_DROP = 4'd2,
        EV_START     = 4'd3,
        EV_COMMAND   = 4'd4,
        EV_LENGTH    = 4'd5,
        EV_PAYLOAD   = 4'd6,
        EV_OVERFLOW  = 4'd7,
        EV_DONE      = 4'd8
    } t_event;

    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] frame_command;
        logic [7:0] payload_index;
        logic [7:0] data_byte;
    } t_result;

endpackage

### src/preamble_postamble_frame_receiver_unit.sv
// Frame receiver: classifies each received byte and tracks frame state.
//
// Input channel s_axis carries one received byte per transaction. Output
// channel m_axis carries one result per input byte: the event code on
// tuser and the byte, payload index, command and length on tdata.
// The single-bit setup register is written through i_cfg_we/i_cfg_wdata;
// every write also returns the parser to hunting for a preamble.
//
// A byte accepted at a clock edge is registered in the output register, or in
// the skid register while the output register holds a stalled result.
// Throughput is one byte per cycle while s_axis_tready is high.
// A two-entry output stage (result register plus skid register) lets the
// block take a byte while a finished result still waits. When the receiver
// stalls, at most two results are held and then s_axis_tready drops until
// the skid entry drains.
//
// Reset clears setup mode, all parser state and both output entries;
// the block accepts bytes in the first cycle after reset.
module preamble_postamble_frame_receiver_unit
    import ppfr_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // setup_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] data_byte, [15:8] payload_index,
                                         // [23:16] frame_command, [31:24] frame_length
    output logic [3:0]  m_axis_tuser     // [3:0] event_res
);

    localparam int unsigned HP_W = $clog2(BUF_DEPTH + 1);

    logic                r_setup_mode;
    logic                r_in_frame,   n_in_frame;
    logic [HP_W-1:0]     r_hunt_pos,   n_hunt_pos;
    logic [7:0]          r_prev_byte,  n_prev_byte;
    logic [COUNT_W-1:0]  r_count,      n_count;
    logic [7:0]          r_command,    n_command;
    logic [7:0]          r_length,     n_length;

    t_event              w_event;
    logic [7:0]          w_index;
    logic [COUNT_W-1:0]  w_pos;
    t_result             w_result;

    logic                r_out_valid;
    t_result             r_out_data;
    t_event              r_out_event;
    logic                r_skid_valid;
    t_result             r_skid_data;
    t_event              r_skid_event;

    logic                w_accept;
    logic                w_out_free;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_pos = r_count - COUNT_W'(2);

    // Per-byte parser update.
    always_comb begin
        n_in_frame  = r_in_frame;
        n_hunt_pos  = r_hunt_pos;
        n_prev_byte = r_prev_byte;
        n_count     = r_count;
        n_command   = r_command;
        n_length    = r_length;
        w_index     = '0;
        w_event     = EV_PASS;
        if (!r_setup_mode) begin
            w_event = EV_PASS;
        end else if (r_in_frame) begin
            if (s_axis_tdata == POSTAMBLE_BYTE && r_count >= COUNT_W'(2)
                    && w_pos == {1'b0, r_length}) begin
                w_event    = EV_DONE;
                n_in_frame = 1'b0;
                n_hunt_pos = '0;
            end else begin
                if (r_count == '0) begin
                    n_command = s_axis_tdata;
                    w_event   = EV_COMMAND;
                end else if (r_count == COUNT_W'(1)) begin
                    n_length = s_axis_tdata;
                    w_event  = EV_LENGTH;
                end else begin
                    w_event = (w_pos < COUNT_W'(BUF_DEPTH)) ? EV_PAYLOAD : EV_OVERFLOW;
                    w_index = w_pos[COUNT_W-1] ? 8'hFF : w_pos[7:0];
                end
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
        end else if (r_hunt_pos != '0 && s_axis_tdata == PREAMBLE_BYTE
                     && r_prev_byte == PREAMBLE_BYTE) begin
            w_event    = EV_START;
            n_in_frame = 1'b1;
            n_hunt_pos = '0;
            n_count    = '0;
            n_length   = '0;
        end else if (r_hunt_pos >= HP_W'(BUF_DEPTH)) begin
            w_event    = EV_HUNT_DROP;
            n_hunt_pos = '0;
        end else begin
            w_event     = EV_HUNT;
            n_prev_byte = s_axis_tdata;
            n_hunt_pos  = r_hunt_pos + HP_W'(1);
        end
    end

    always_comb begin
        w_result.data_byte     = s_axis_tdata;
        w_result.payload_index = w_index;
        w_result.frame_command = n_command;
        w_result.frame_length  = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_mode <= 1'b0;
            r_in_frame   <= 1'b0;
            r_hunt_pos   <= '0;
            r_prev_byte  <= '0;
            r_count      <= '0;
            r_command    <= '0;
            r_length     <= '0;
        end else if (i_cfg_we) begin
            r_setup_mode <= i_cfg_wdata;
            r_in_frame   <= 1'b0;
            r_hunt_pos   <= '0;
            r_prev_byte  <= '0;
            r_count      <= '0;
        end else if (w_accept) begin
            r_in_frame  <= n_in_frame;
            r_hunt_pos  <= n_hunt_pos;
            r_prev_byte <= n_prev_byte;
            r_count     <= n_count;
            r_command   <= n_command;
            r_length    <= n_length;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (m_axis_tready) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (w_out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data  <= r_skid_data;
                r_out_event <= r_skid_event;
            end
        end else if (w_accept) begin
            if (w_out_free) begin
                r_out_data  <= w_result;
                r_out_event <= w_event;
            end else begin
                r_skid_data  <= w_result;
                r_skid_event <= w_event;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_event;

endmodule

### src/ppfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
module ppfr_checker
    import ppfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only payload and overflow events carry an index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != EV_PAYLOAD && m_axis_tuser != EV_OVERFLOW
            |-> m_axis_tdata[15:8] == 8'h00)
        else $error("payload index on a non-payload event");

    // A frame start clears the declared length and carries the preamble byte.
    a_start_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == EV_START
            |-> m_axis_tdata[31:24] == 8'h00 && m_axis_tdata[7:0] == PREAMBLE_BYTE)
        else $error("frame start with bad fields");

    // A finished frame is marked by the postamble byte.
    a_done_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == EV_DONE |-> m_axis_tdata[7:0] == POSTAMBLE_BYTE)
        else $error("frame done without postamble byte");

endmodule

bind preamble_postamble_frame_receiver_unit ppfr_checker u_ppfr_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the preamble/postamble frame receiver unit.
module testbench;
    import ppfr_pkg::*;

    localparam int BUF_DEPTH    = 128;
    localparam int RANDOM_BYTES = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 3;
    localparam int MAX_GAP      = 12;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_event  ev;
        t_result res;
    } t_rx_report;

    // One directed step: either a setup register write or one received byte,
    // with a hand-written expectation where the outcome is obvious.
    typedef struct packed {
        logic       setup_write;
        logic [7:0] value;
        logic       typed;
        t_event     ev;
        logic [7:0] idx;
        logic [7:0] cmd;
        logic [7:0] len;
    } t_step_row;

    localparam t_step_row STEP_TABLE [0:23] = '{
        '{1'b0, 8'h00, 1'b1, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 1'b1, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b1, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b1, 8'h01, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b1, EV_HUNT,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b1, EV_START,    8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hA5, 1'b1, EV_COMMAND,  8'h00, 8'hA5, 8'h00},
        '{1'b0, 8'h02, 1'b1, EV_LENGTH,   8'h00, 8'hA5, 8'h02},
        '{1'b0, 8'hFD, 1'b1, EV_PAYLOAD,  8'h00, 8'hA5, 8'h02},
        '{1'b0, 8'h00, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFD, 1'b1, EV_DONE,     8'h00, 8'hA5, 8'h02},
        '{1'b0, 8'hFE, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b1, EV_START,    8'h00, 8'hA5, 8'h00},
        '{1'b0, 8'hFD, 1'b1, EV_COMMAND,  8'h00, 8'hFD, 8'h00},
        '{1'b0, 8'h00, 1'b1, EV_LENGTH,   8'h00, 8'hFD, 8'h00},
        '{1'b0, 8'hFD, 1'b1, EV_DONE,     8'h00, 8'hFD, 8'h00},
        '{1'b1, 8'h01, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFE, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'h5A, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b1, 8'h00, 1'b0, EV_PASS,     8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 1'b1, EV_PASS,     8'h00, 8'h5A, 8'h00}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    // Predicted parser state, mirrored from the received byte stream.
    logic        mode_on;
    logic        framing;
    int unsigned hunt_fill;
    logic [7:0]  last_hunt_byte;
    int unsigned rx_count;
    logic [7:0]  cmd_q;
    logic [7:0]  len_q;

    t_rx_report pending_reports [$];
    bit  src_gaps  = 1'b1;
    bit  sink_gaps = 1'b1;
    int  bytes_sent;
    int  results_checked;
    int  mismatches;
    int  cycle_count;
    int  event_tally [0:8];

    preamble_postamble_frame_receiver_unit #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A setup write drops any frame in progress and clears the hunt history.
    function void rearm_parser(input logic setup);
        mode_on        = setup;
        framing        = 1'b0;
        hunt_fill      = 0;
        last_hunt_byte = 8'h00;
        rx_count       = 0;
    endfunction

    function automatic t_rx_report classify_rx_byte(input logic [7:0] b);
        t_rx_report  rep;
        int unsigned pos;
        rep.ev                = EV_PASS;
        rep.res.payload_index = 8'h00;
        if (!mode_on) begin
            rep.ev = EV_PASS;
        end else if (framing) begin
            if (b == POSTAMBLE_BYTE && rx_count >= 2 && rx_count - 2 == len_q) begin
                rep.ev    = EV_DONE;
                framing   = 1'b0;
                hunt_fill = 0;
            end else begin
                if (rx_count == 0) begin
                    cmd_q  = b;
                    rep.ev = EV_COMMAND;
                end else if (rx_count == 1) begin
                    len_q  = b;
                    rep.ev = EV_LENGTH;
                end else begin
                    pos    = rx_count - 2;
                    rep.ev = (pos < BUF_DEPTH) ? EV_PAYLOAD : EV_OVERFLOW;
                    rep.res.payload_index = (pos > 255) ? 8'hFF : 8'(pos);
                end
                if (rx_count < int'(COUNT_MAX))
                    rx_count++;
            end
        end else if (hunt_fill > 0 && b == PREAMBLE_BYTE && last_hunt_byte == PREAMBLE_BYTE) begin
            rep.ev    = EV_START;
            framing   = 1'b1;
            hunt_fill = 0;
            rx_count  = 0;
            len_q     = 8'h00;
        end else if (hunt_fill >= BUF_DEPTH) begin
            rep.ev    = EV_HUNT_DROP;
            hunt_fill = 0;
        end else begin
            rep.ev         = EV_HUNT;
            last_hunt_byte = b;
            hunt_fill++;
        end
        rep.res.data_byte     = b;
        rep.res.frame_command = cmd_q;
        rep.res.frame_length  = len_q;
        return rep;
    endfunction

    // Leans toward the framing bytes and the value extremes.
    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        case (roll)
            0, 1:    return PREAMBLE_BYTE;
            2, 3:    return POSTAMBLE_BYTE;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                             input t_rx_report typed_rep = '0);
        int         gap;
        t_rx_report rep;
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        rep = classify_rx_byte(b);
        pending_reports.push_back(use_typed ? typed_rep : rep);
        bytes_sent++;
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setup(input logic setup);
        go_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= setup;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rearm_parser(setup);
    endtask

    // Preamble, command, length, payload bytes and an optional postamble.
    // A payload byte in the closing position is kept off the postamble value
    // so that an overrun frame really runs past its declared length.
    task automatic send_frame(input int len, input int n_payload, input bit close);
        logic [7:0] b;
        send_byte(PREAMBLE_BYTE);
        send_byte(PREAMBLE_BYTE);
        send_byte(pick_byte());
        send_byte(8'(len));
        for (int i = 0; i < n_payload; i++) begin
            b = pick_byte();
            if (i == len && b == POSTAMBLE_BYTE)
                b = 8'h00;
            send_byte(b);
        end
        if (close)
            send_byte(POSTAMBLE_BYTE);
    endtask

    // Result side: random stalls, every transaction compared with the oldest prediction.
    initial begin
        int         gap;
        t_rx_report want;
        t_result    got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = t_result'(m_axis_tdata);
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: event %0d tdata %h", m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_reports.pop_front();
                results_checked++;
                event_tally[int'(want.ev)]++;
                if (m_axis_tuser !== want.ev || got.data_byte !== want.res.data_byte ||
                    got.payload_index !== want.res.payload_index ||
                    got.frame_command !== want.res.frame_command ||
                    got.frame_length !== want.res.frame_length) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"result %0d: expected event %0d byte %h index %h cmd %h len %h,",
                                  " got event %0d byte %h index %h cmd %h len %h"},
                                 results_checked, want.ev, want.res.data_byte,
                                 want.res.payload_index, want.res.frame_command,
                                 want.res.frame_length, m_axis_tuser, got.data_byte,
                                 got.payload_index, got.frame_command, got.frame_length);
                end
            end
        end
    end

    initial begin
        int         phase;
        int         len;
        int         stop;
        int         goal;
        bit         setup;
        logic [7:0] b;
        t_rx_report typed_rep;
        cmd_q = 8'h00;
        len_q = 8'h00;
        rearm_parser(1'b0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(STEP_TABLE); r++) begin
            if (STEP_TABLE[r].setup_write) begin
                write_setup(STEP_TABLE[r].value[0]);
            end else begin
                typed_rep.ev  = STEP_TABLE[r].ev;
                typed_rep.res = {STEP_TABLE[r].len, STEP_TABLE[r].cmd,
                                 STEP_TABLE[r].idx, STEP_TABLE[r].value};
                send_byte(STEP_TABLE[r].value, STEP_TABLE[r].typed, typed_rep);
            end
        end

        // The first three phases reach the hunt buffer limit, payload past the
        // buffer, and a frame that runs until the byte counter saturates.
        goal  = bytes_sent + RANDOM_BYTES;
        phase = 0;
        while (bytes_sent < goal) begin
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            case (phase)
                0: begin
                    write_setup(1'b1);
                    for (int i = 0; i < 140; i++) begin
                        b = pick_byte();
                        if (b == PREAMBLE_BYTE)
                            b = 8'h7E;
                        send_byte(b);
                    end
                    send_frame(3, 3, 1'b1);
                end
                1: begin
                    write_setup(1'b1);
                    len = $urandom_range(130, 255);
                    send_frame(len, len, 1'b1);
                end
                2: begin
                    write_setup(1'b1);
                    send_frame(255, 520, 1'b1);
                end
                default: begin
                    setup = ($urandom_range(0, 4) != 0);
                    write_setup(setup);
                    stop = bytes_sent + $urandom_range(20, 80);
                    while (bytes_sent < stop) begin
                        if (!setup) begin
                            send_byte(pick_byte());
                        end else begin
                            case ($urandom_range(0, 9))
                                0, 1, 2, 3, 4, 5: begin
                                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                                      : $urandom_range(0, 12);
                                    send_frame(len, len, 1'b1);
                                end
                                6: repeat ($urandom_range(1, 10)) send_byte(pick_byte());
                                7: begin
                                    len = $urandom_range(0, 8);
                                    send_frame(len, len + $urandom_range(1, 5),
                                               1'($urandom_range(0, 1)));
                                end
                                8: begin
                                    len = $urandom_range(2, 12);
                                    send_frame(len, $urandom_range(0, len - 1), 1'b0);
                                end
                                default: repeat ($urandom_range(1, 6))
                                    send_byte($urandom_range(0, 1) ? PREAMBLE_BYTE
                                                                   : POSTAMBLE_BYTE);
                            endcase
                        end
                    end
                end
            endcase
            phase++;
        end

        go_idle();
        $display("Run covered %0d received bytes over %0d setup phases, %0d results checked.",
                 bytes_sent, phase, results_checked);
        $display("Frames closed %0d, hunt drops %0d, overflow bytes %0d, pass-through bytes %0d.",
                 event_tally[int'(EV_DONE)], event_tally[int'(EV_HUNT_DROP)],
                 event_tally[int'(EV_OVERFLOW)], event_tally[int'(EV_PASS)]);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
